### sv/ivc_pkg.sv
// Shared types, constants and helpers for the integer to radix digit converter.
package ivc_pkg;

    localparam int VALUE_W     = 31;
    localparam int BASE_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int CHAR_W      = 7;
    localparam int QUEUE_DEPTH = 2;

    // Division works on a zero-padded word, a fixed chunk of quotient bits per cycle
    localparam int DIV_W       = 32;
    localparam int CHUNK_W     = 8;
    localparam int CHUNKS      = DIV_W / CHUNK_W;
    localparam int CHUNK_CNT_W = $clog2(CHUNKS);

    localparam logic [BASE_W-1:0]  BASE_MIN   = 5'd2;
    localparam logic [BASE_W-1:0]  BASE_MAX   = 5'd16;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
    localparam logic [CHAR_W-1:0]  ASCII_F    = 7'd70;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

    // One conversion request as it travels from front to back
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BASE_W-1:0]  base;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_POP_FIRST,
        ST_POP
    } back_state_t;

    // Map a digit to its ASCII character, '0'-'9' then 'A'-'F'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DIGIT_TEN)
            return ASCII_ZERO + d_ext;
        else
            return ASCII_A + d_ext - {{(CHAR_W-DIGIT_W){1'b0}}, DIGIT_TEN};
    endfunction

endpackage

### sv/ivc_front.sv
// Front end: accepts words, drops those that give no digits, stages the rest.
module ivc_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ivc_pkg::VALUE_W-1:0] value,
    input  logic [ivc_pkg::BASE_W-1:0]  base,
    output logic                        push_valid,
    input  logic                        push_ready,
    output ivc_pkg::job_t               push_job
);
    import ivc_pkg::*;

    logic stage_valid_reg;
    logic stage_valid_next;
    job_t stage_job_reg;
    logic in_fire;
    logic keep;

    // Classify: a zero value or a base outside 2..16 yields no digits
    assign keep = (value != '0) && (base >= BASE_MIN) && (base <= BASE_MAX);

    assign in_ready   = !stage_valid_reg || push_ready;
    assign in_fire    = in_valid && in_ready;
    assign push_valid = stage_valid_reg;
    assign push_job   = stage_job_reg;

    // Hold the staged word until the queue takes it
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_fire)
            stage_valid_next = keep;
        else if (push_ready)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && keep)
        begin
            stage_job_reg.value <= value;
            stage_job_reg.base  <= base;
        end
    end

endmodule

### sv/ivc_queue.sv
// Two-entry job queue between the front end and the conversion engine.
module ivc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ivc_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ivc_pkg::job_t pop_job
);
    import ivc_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push_fire;
    logic             pop_fire;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_fire)
            wr_ptr_next = (wr_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop_fire)
            rd_ptr_next = (rd_ptr_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push_fire && !pop_fire)
            count_next = count_reg + 1'b1;
        else if (!push_fire && pop_fire)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push_fire)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

### sv/ivc_back.sv
// Conversion engine: chunked radix division onto a digit stack, then pop to ASCII.
module ivc_back #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       job_valid,
    output logic                       job_ready,
    input  ivc_pkg::job_t              job,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ivc_pkg::CHAR_W-1:0] digit_char,
    output logic                       last_digit
);
    import ivc_pkg::*;

    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int PTR_W = $clog2(STACK_DEPTH + 1);

    back_state_t            state_reg;
    back_state_t            state_next;
    logic [DIV_W-1:0]       quo_reg;
    logic [DIV_W-1:0]       quo_next;
    logic [BASE_W-1:0]      base_reg;
    logic [BASE_W-1:0]      rem_reg;
    logic [BASE_W-1:0]      rem_next;
    logic [CHUNK_CNT_W-1:0] chunk_reg;
    logic [CHUNK_CNT_W-1:0] chunk_next;
    logic [PTR_W-1:0]       sp_reg;
    logic [PTR_W-1:0]       sp_next;
    logic [DIGIT_W-1:0]     stack_mem [STACK_DEPTH];
    logic [DIGIT_W-1:0]     rd_data_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [CHAR_W-1:0]      char_reg;
    logic                   last_reg;

    logic                   job_fire;
    logic                   last_chunk;
    logic                   div_done;
    logic                   push_en;
    logic                   rd_en;
    logic                   load_ok;
    logic                   load_en;
    logic [IDX_W-1:0]       rd_addr;
    logic [BASE_W-1:0]      step_rem;
    logic [CHUNK_W-1:0]     step_q;
    logic [DIV_W-1:0]       step_quo;

    assign job_ready  = (state_reg == ST_IDLE);
    assign job_fire   = job_valid && job_ready;
    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;
    assign load_ok    = !out_valid_reg || out_ready;
    assign rd_addr    = IDX_W'(sp_reg - 1'b1);

    // One chunk of restoring division; the remainder stays below the base
    always_comb
    begin
        step_rem = rem_reg;
        step_q   = '0;
        for (int i = 0; i < CHUNK_W; i++)
        begin
            step_rem = {step_rem[BASE_W-2:0], quo_reg[DIV_W-1-i]};
            if (step_rem >= base_reg)
            begin
                step_rem             = step_rem - base_reg;
                step_q[CHUNK_W-1-i] = 1'b1;
            end
        end
        step_quo = {quo_reg[DIV_W-CHUNK_W-1:0], step_q};
    end

    assign last_chunk = (chunk_reg == CHUNK_CNT_W'(CHUNKS - 1));
    assign div_done   = last_chunk
                        && ((step_quo == '0) || (sp_reg + 1'b1 == PTR_W'(STACK_DEPTH)));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (job_fire)
                    state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_POP_FIRST;
            ST_POP_FIRST:
                state_next = ST_POP;
            ST_POP:
                if (load_ok && (sp_reg == '0))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath controls
    always_comb
    begin
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        chunk_next     = chunk_reg;
        sp_next        = sp_reg;
        push_en        = 1'b0;
        rd_en          = 1'b0;
        load_en        = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
                if (job_fire)
                begin
                    quo_next   = DIV_W'(job.value);
                    rem_next   = '0;
                    chunk_next = '0;
                    sp_next    = '0;
                end
            ST_DIV:
            begin
                quo_next   = step_quo;
                chunk_next = chunk_reg + 1'b1;
                rem_next   = step_rem;
                if (last_chunk)
                begin
                    push_en  = 1'b1;
                    sp_next  = sp_reg + 1'b1;
                    rem_next = '0;
                end
            end
            ST_POP_FIRST:
            begin
                rd_en   = 1'b1;
                sp_next = sp_reg - 1'b1;
            end
            ST_POP:
                if (load_ok)
                begin
                    load_en        = 1'b1;
                    out_valid_next = 1'b1;
                    if (sp_reg != '0)
                    begin
                        rd_en   = 1'b1;
                        sp_next = sp_reg - 1'b1;
                    end
                end
            default:
            begin
                sp_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            chunk_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            chunk_reg     <= chunk_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Division operands
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (job_fire)
            base_reg <= job.base;
    end

    // Digit stack: push during division, registered read while popping
    always_ff @(posedge clk)
    begin
        if (push_en)
            stack_mem[sp_reg[IDX_W-1:0]] <= step_rem[DIGIT_W-1:0];
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            char_reg <= digit_to_ascii(rd_data_reg);
            last_reg <= (sp_reg == '0);
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= PTR_W'(STACK_DEPTH))
        else $error("digit stack pointer beyond depth");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (sp_reg == '0))
        else $error("stack not drained when idle");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((char_reg >= ASCII_ZERO) && (char_reg < ASCII_A - 7'd7))
                           || ((char_reg >= ASCII_A) && (char_reg <= ASCII_F))))
        else $error("output character outside digit set");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP && load_ok && sp_reg == '0)
            |=> (state_reg == ST_IDLE && out_valid_reg && last_reg))
        else $error("final digit did not close the conversion");

endmodule

### sv/integer_to_radix_digits_unit.sv
// Top level: converts a non-negative integer to ASCII digits in base 2..16.
//
//   Channel | Handshake            | Fields
//   --------+----------------------+------------------------------
//   in      | in_valid / in_ready  | value[30:0], base[4:0]
//   out     | out_valid / out_ready| digit_char[6:0], last_digit
//
// An item's digits come from repeated division (eight quotient bits
// per cycle through a shared restoring divider, four chunks per digit), then
// the engine primes the stack read and pops the digits, up to 31 of them for
// a base-2 result. One item converts at a time.
// A zero value or a base outside 2..16 is dropped in the front end and gives
// no words. Reset clears all control state; the stack contents are not reset.
// The front end and a two-entry queue keep taking words while the engine
// waits on a stalled output.
module integer_to_radix_digits_unit #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ivc_pkg::VALUE_W-1:0] value,
    input  logic [ivc_pkg::BASE_W-1:0]  base,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ivc_pkg::CHAR_W-1:0]  digit_char,
    output logic                        last_digit
);
    import ivc_pkg::*;

    logic push_valid;
    logic push_ready;
    job_t push_job;
    logic job_valid;
    logic job_ready;
    job_t job;

    ivc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .base       (base),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    ivc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (job_valid),
        .pop_ready  (job_ready),
        .pop_job    (job)
    );

    ivc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the integer to radix digit converter.
module tb_top;

    import ivc_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int HOLD_AFTER  = 60;
    localparam int DRAIN_WAIT  = 200;
    localparam int RANDOM_JOBS = 430;

    // One output word: ASCII digit and the final-digit flag
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_word_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [VALUE_W-1:0]  value     = '0;
    logic [BASE_W-1:0]   base      = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAR_W-1:0]   digit_char;
    logic                last_digit;
    logic                out_hold  = 1'b0;

    job_t        pending_jobs [$];
    digit_word_t digits_due   [$];
    int          total_jobs   = 0;
    int          jobs_sent    = 0;
    int          errors       = 0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          rx_cycles    = 0;
    int          idle_cycles  = 0;
    int          hold_left    = 0;
    int          hold_seen    = 0;
    bit          hold_done    = 1'b0;

    integer_to_radix_digits_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .base       (base),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Divide down the value and queue its digits, most significant first
    function automatic void convert_to_digits(input logic [VALUE_W-1:0] v,
                                              input logic [BASE_W-1:0] b);
        logic [DIGIT_W-1:0] remainders [$];
        logic [DIV_W-1:0]   rest;
        logic [DIGIT_W-1:0] d;
        digit_word_t        w;
        if (b < BASE_MIN || b > BASE_MAX)
            return;
        rest = {1'b0, v};
        while (rest != '0)
        begin
            remainders.push_back(DIGIT_W'(rest % DIV_W'(b)));
            rest = rest / DIV_W'(b);
        end
        for (int k = remainders.size() - 1; k >= 0; k--)
        begin
            d = remainders[k];
            w.code = (d < DIGIT_TEN) ? ASCII_ZERO + CHAR_W'(d)
                                     : ASCII_A + CHAR_W'(d - DIGIT_TEN);
            w.last = (k == 0);
            digits_due.push_back(w);
        end
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_stall();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 40)
            return VALUE_W'($urandom_range(1, 255));
        if (r < 65)
            return VALUE_W'($urandom_range(256, 65535));
        if (r < 90)
            return VALUE_W'($urandom);
        return VALUE_W'($urandom) | {1'b1, {(VALUE_W-1){1'b0}}};
    endfunction

    function automatic logic [BASE_W-1:0] pick_base();
        if ($urandom_range(0, 9) == 0)
            return BASE_W'($urandom_range(0, 31));
        return BASE_W'($urandom_range(BASE_MIN, BASE_MAX));
    endfunction

    function automatic void add_job(input logic [VALUE_W-1:0] v, input logic [BASE_W-1:0] b);
        job_t j;
        j.value = v;
        j.base  = b;
        pending_jobs.push_back(j);
        total_jobs++;
    endfunction

    function automatic void note_mismatch(input string what);
        errors++;
        if (errors <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endfunction

    // Offer queued words, hold each until taken, insert random gaps
    always @(posedge clk or negedge rst_n)
    begin : feed_words
        job_t j;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                convert_to_digits(value, base);
                jobs_sent++;
            end
            if (!(in_valid && !in_ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_jobs.size() > 0)
                begin
                    j = pending_jobs.pop_front();
                    value    <= j.value;
                    base     <= j.base;
                    in_valid <= 1'b1;
                    gap_left = ((jobs_sent / 50) % 4 == 3) ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Take output words, check each against the oldest expected digit
    always @(posedge clk or negedge rst_n)
    begin : take_words
        digit_word_t want;
        logic        ready_next;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            rx_cycles  = 0;
        end
        else
        begin
            rx_cycles++;
            if (out_valid && out_ready)
            begin
                if (digits_due.size() == 0)
                    note_mismatch($sformatf("unexpected word digit_char=%0d last_digit=%0b",
                                            digit_char, last_digit));
                else
                begin
                    want = digits_due.pop_front();
                    if (digit_char !== want.code)
                        note_mismatch($sformatf("digit_char expected %0d ('%c') got %0d",
                                                want.code, want.code, digit_char));
                    if (last_digit !== want.last)
                        note_mismatch($sformatf("last_digit expected %0b got %0b",
                                                want.last, last_digit));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                ready_next = 1'b0;
            end
            else if ((rx_cycles / 400) % 5 != 4 && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_stall() - 1;
                ready_next = 1'b0;
            end
            else
                ready_next = 1'b1;
            out_ready <= ready_next && !out_hold;
        end
    end

    // Hold off the receiver once for a long stretch so the input backs up
    always @(posedge clk or negedge rst_n)
    begin : long_hold
        if (!rst_n)
        begin
            out_hold <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
            hold_done = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                hold_seen++;
            if (hold_left > 0)
                hold_left--;
            else if (!hold_done && hold_seen >= HOLD_AFTER)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            out_hold <= (hold_left > 0);
        end
    end

    // Abort if neither channel moves a word for too long
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("integer_to_radix_digits_unit verification failed");
                $finish;
            end
        end
    end

    initial
    begin : run_control
        int useful;
        // Directed: zero value, extremes, bases out of range, every base
        add_job('0, 5'd10);
        add_job('0, 5'd31);
        add_job({VALUE_W{1'b1}}, BASE_MIN);
        add_job({VALUE_W{1'b1}}, 5'd10);
        add_job({VALUE_W{1'b1}}, BASE_MAX);
        add_job(VALUE_W'(1), BASE_MIN);
        add_job({VALUE_W{1'b1}}, 5'd0);
        add_job({VALUE_W{1'b1}}, 5'd1);
        add_job({VALUE_W{1'b1}}, 5'd17);
        add_job({VALUE_W{1'b1}}, 5'd31);
        for (int b = BASE_MIN; b <= BASE_MAX; b++)
            add_job(VALUE_W'(b * b * b - 1), BASE_W'(b));

        // Random: count only words that yield digits
        useful = 0;
        while (useful < RANDOM_JOBS)
        begin
            job_t j;
            j.value = pick_value();
            j.base  = pick_base();
            add_job(j.value, j.base);
            if (j.value != '0 && j.base >= BASE_MIN && j.base <= BASE_MAX)
                useful++;
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (jobs_sent < total_jobs || digits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("integer_to_radix_digits_unit verification clean");
        else
            $display("integer_to_radix_digits_unit verification failed");
        $finish;
    end

endmodule
